>>> sv/text_command_line_decoder_defines.svh
// ----------------------------------------------------------------------------
// Text command line decoder assertion macros
// Immediate-cycle and next-cycle implication checks on the rising clock.
// ----------------------------------------------------------------------------
`ifndef TEXT_COMMAND_LINE_DECODER_DEFINES_SVH
`define TEXT_COMMAND_LINE_DECODER_DEFINES_SVH

// check cons in the cycle where ante holds
`define TCLD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante holds
`define TCLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/tcld_pkg.sv
// ----------------------------------------------------------------------------
// Text command line decoder package
// Shared widths, character codes, keyword tables, codes and result struct.
// ----------------------------------------------------------------------------
package tcld_pkg;

   localparam int LINE_CAPACITY_DEFAULT = 80;
   localparam int BYTE_W                = 8;
   localparam int CODE_W                = 3;
   localparam int TONE_W                = 16;
   localparam int ACC_W                 = 32;
   localparam int DIGIT_W               = 4;
   localparam int CSR_INDEX_W           = 8;
   localparam int KEYWORD_COUNT         = 7;
   localparam int KEYWORD_MAX           = 8;
   localparam int KEYWORD_POS_W         = 3;
   localparam int KEYWORD_LEN_W         = 4;
   localparam int BEEP_BIT              = 6;
   localparam int ARG_START             = 4;

   localparam logic [TONE_W-1:0] TONE_HZ_RESET = 16'd2000;
   localparam logic [TONE_W-1:0] TONE_MS_RESET = 16'd80;

   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0B;
   localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   typedef enum logic [CODE_W-1:0] {
      CMD_HELP     = 3'd0,
      CMD_STATUS   = 3'd1,
      CMD_LED1_ON  = 3'd2,
      CMD_LED1_OFF = 3'd3,
      CMD_LED2_ON  = 3'd4,
      CMD_LED2_OFF = 3'd5,
      CMD_BEEP     = 3'd6,
      CMD_UNKNOWN  = 3'd7
   } cmd_code_type;

   typedef enum logic [2:0] {
      ARG_WAIT_HZ = 3'd0,
      ARG_HZ      = 3'd1,
      ARG_WAIT_MS = 3'd2,
      ARG_MS      = 3'd3,
      ARG_DONE    = 3'd4
   } arg_phase_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TONE_HZ = 8'd0,
      CSR_TONE_MS = 8'd1
   } csr_index_type;

   // help, status, led1 on, led1 off, led2 on, led2 off, beep
   localparam logic [BYTE_W-1:0] KEYWORD_CHARS [KEYWORD_COUNT][KEYWORD_MAX] = '{
      '{8'h68, 8'h65, 8'h6C, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h73, 8'h74, 8'h61, 8'h74, 8'h75, 8'h73, 8'h00, 8'h00},
      '{8'h6C, 8'h65, 8'h64, 8'h31, 8'h20, 8'h6F, 8'h6E, 8'h00},
      '{8'h6C, 8'h65, 8'h64, 8'h31, 8'h20, 8'h6F, 8'h66, 8'h66},
      '{8'h6C, 8'h65, 8'h64, 8'h32, 8'h20, 8'h6F, 8'h6E, 8'h00},
      '{8'h6C, 8'h65, 8'h64, 8'h32, 8'h20, 8'h6F, 8'h66, 8'h66},
      '{8'h62, 8'h65, 8'h65, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [KEYWORD_LEN_W-1:0] KEYWORD_LEN [KEYWORD_COUNT] = '{
      4'd4, 4'd6, 4'd7, 4'd8, 4'd7, 4'd8, 4'd4
   };

   typedef struct packed {
      logic              hit;
      cmd_code_type      code;
      logic [TONE_W-1:0] tone_hz;
      logic [TONE_W-1:0] tone_ms;
   } line_result_type;

   function automatic logic is_blank(input logic [BYTE_W-1:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
   endfunction

   function automatic logic is_digit(input logic [BYTE_W-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

>>> sv/text_command_line_decoder.sv
// ----------------------------------------------------------------------------
// Text command line decoder
// Builds a command line from received bytes and reports one command per
// non-empty line, with beep frequency and duration arguments.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_rx_byte
//   rsp      out        rsp_valid / rsp_stall  rsp_command_code, rsp_tone_hz,
//                                              rsp_tone_ms
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One item per cycle unless req_stall holds it; an item goes through an input
// register, the line state update and the result register that drives rsp_valid.
// Reset clears the line state and loads the tone defaults 2000 Hz and 80 ms.
// rsp_stall holds only items that end a non-empty line; other bytes keep flowing.
// csr_ready is always high.
// ----------------------------------------------------------------------------
`include "text_command_line_decoder_defines.svh"

module text_command_line_decoder #(
   parameter int LINE_CAPACITY = tcld_pkg::LINE_CAPACITY_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tcld_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tcld_pkg::CODE_W-1:0]      rsp_command_code,
   output logic [tcld_pkg::TONE_W-1:0]      rsp_tone_hz,
   output logic [tcld_pkg::TONE_W-1:0]      rsp_tone_ms,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcld_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tcld_pkg::TONE_W-1:0]      csr_wdata
);
   import tcld_pkg::*;

   logic                in_valid_ff;
   logic                in_valid_in;
   logic [BYTE_W-1:0]   in_byte_ff;
   logic [BYTE_W-1:0]   in_byte_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   cmd_code_type        rsp_code_ff;
   cmd_code_type        rsp_code_in;
   logic [TONE_W-1:0]   rsp_hz_ff;
   logic [TONE_W-1:0]   rsp_hz_in;
   logic [TONE_W-1:0]   rsp_ms_ff;
   logic [TONE_W-1:0]   rsp_ms_in;
   logic [TONE_W-1:0]   tone_hz_ff;
   logic [TONE_W-1:0]   tone_hz_in;
   logic [TONE_W-1:0]   tone_ms_ff;
   logic [TONE_W-1:0]   tone_ms_in;

   line_result_type     line_result;
   logic                out_free;
   logic                advance;
   logic                req_take;

   tcld_line_state #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_line_state (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (in_valid_ff),
      .step            (advance),
      .rx_byte         (in_byte_ff),
      .default_tone_hz (tone_hz_ff),
      .default_tone_ms (tone_ms_ff),
      .result          (line_result)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!line_result.hit || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_code = rsp_code_ff;
   assign rsp_tone_hz      = rsp_hz_ff;
   assign rsp_tone_ms      = rsp_ms_ff;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      in_byte_in   = req_take ? req_rx_byte : in_byte_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_code_in  = rsp_code_ff;
      rsp_hz_in    = rsp_hz_ff;
      rsp_ms_in    = rsp_ms_ff;
      if (advance && line_result.hit) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = line_result.code;
         rsp_hz_in    = line_result.tone_hz;
         rsp_ms_in    = line_result.tone_ms;
      end
      tone_hz_in = tone_hz_ff;
      tone_ms_in = tone_ms_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TONE_HZ: tone_hz_in = csr_wdata;
            CSR_TONE_MS: tone_ms_in = csr_wdata;
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tone_hz_ff   <= TONE_HZ_RESET;
         tone_ms_ff   <= TONE_MS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         tone_hz_ff   <= tone_hz_in;
         tone_ms_ff   <= tone_ms_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      rsp_code_ff <= rsp_code_in;
      rsp_hz_ff   <= rsp_hz_in;
      rsp_ms_ff   <= rsp_ms_in;
   end

   `TCLD_ASSERT_NOW(a_tone_zero_unless_beep, clock, reset,
      rsp_valid_ff && (rsp_code_ff != CMD_BEEP), (rsp_hz_ff == '0) && (rsp_ms_ff == '0),
      "tone fields nonzero on a non-beep result")
   `TCLD_ASSERT_NEXT(a_input_held, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_byte_ff), "held input item changed or dropped")
   `TCLD_ASSERT_NEXT(a_result_loaded, clock, reset, advance && line_result.hit,
      rsp_valid_ff, "line result not loaded into result register")
   `TCLD_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && rsp_stall,
      !(advance && line_result.hit), "pending result overwritten")

endmodule

>>> sv/tcld_digit_acc.sv
// ----------------------------------------------------------------------------
// Decimal digit accumulate
// Computes acc * 10 + digit, saturating at the all-ones accumulator value.
// ----------------------------------------------------------------------------
module tcld_digit_acc (
   input  logic [tcld_pkg::ACC_W-1:0]   acc,
   input  logic [tcld_pkg::DIGIT_W-1:0] digit,
   output logic [tcld_pkg::ACC_W-1:0]   acc_next
);
   import tcld_pkg::*;

   localparam int SUM_W = ACC_W + 4;

   logic [SUM_W-1:0] sum;

   assign sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + SUM_W'(digit);

   assign acc_next = (sum[SUM_W-1:ACC_W] != '0) ? '1 : sum[ACC_W-1:0];

endmodule

>>> sv/tcld_line_state.sv
// ----------------------------------------------------------------------------
// Command line state
// Tracks kept length, keyword match flags, beep argument parsing and the
// decimal accumulators; forms the result for a line terminator.
// ----------------------------------------------------------------------------
module tcld_line_state #(
   parameter int LINE_CAPACITY = tcld_pkg::LINE_CAPACITY_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   input  logic                        step,
   input  logic [tcld_pkg::BYTE_W-1:0] rx_byte,
   input  logic [tcld_pkg::TONE_W-1:0] default_tone_hz,
   input  logic [tcld_pkg::TONE_W-1:0] default_tone_ms,
   output tcld_pkg::line_result_type   result
);
   import tcld_pkg::*;

   localparam int LEN_W = $clog2(LINE_CAPACITY);
   localparam int CMP_W = (LEN_W > KEYWORD_LEN_W) ? LEN_W : KEYWORD_LEN_W;
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_CAPACITY - 1);

   logic [LEN_W-1:0]         line_len_ff;
   logic [LEN_W-1:0]         line_len_in;
   logic [KEYWORD_COUNT-1:0] flags_ff;
   logic [KEYWORD_COUNT-1:0] flags_in;
   arg_phase_type            arg_phase_ff;
   arg_phase_type            arg_phase_in;
   logic [ACC_W-1:0]         hz_acc_ff;
   logic [ACC_W-1:0]         hz_acc_in;
   logic [ACC_W-1:0]         ms_acc_ff;
   logic [ACC_W-1:0]         ms_acc_in;

   logic [ACC_W-1:0]         hz_acc_next;
   logic [ACC_W-1:0]         ms_acc_next;
   logic [CMP_W-1:0]         line_len_cmp;
   logic                     is_term;
   logic                     digit;
   logic                     blank;

   tcld_digit_acc u_hz_acc (
      .acc      (hz_acc_ff),
      .digit    (rx_byte[DIGIT_W-1:0]),
      .acc_next (hz_acc_next)
   );

   tcld_digit_acc u_ms_acc (
      .acc      (ms_acc_ff),
      .digit    (rx_byte[DIGIT_W-1:0]),
      .acc_next (ms_acc_next)
   );

   assign line_len_cmp = CMP_W'(line_len_ff);
   assign is_term      = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
   assign digit        = is_digit(rx_byte);
   assign blank        = is_blank(rx_byte);

   // result for a terminator on a non-empty line
   always_comb begin
      result         = '0;
      result.code    = CMD_UNKNOWN;
      result.hit     = item_valid && is_term && (line_len_ff != '0);
      for (int k = BEEP_BIT - 1; k >= 0; k--) begin
         if (flags_ff[k] && (line_len_cmp == CMP_W'(KEYWORD_LEN[k]))) begin
            result.code = cmd_code_type'(CODE_W'(k));
         end
      end
      if ((result.code == CMD_UNKNOWN) && flags_ff[BEEP_BIT] &&
          (line_len_cmp >= CMP_W'(ARG_START))) begin
         result.code    = CMD_BEEP;
         result.tone_hz = (hz_acc_ff != '0) ? hz_acc_ff[TONE_W-1:0] : default_tone_hz;
         result.tone_ms = (ms_acc_ff != '0) ? ms_acc_ff[TONE_W-1:0] : default_tone_ms;
      end
   end

   always_comb begin
      line_len_in  = line_len_ff;
      flags_in     = flags_ff;
      arg_phase_in = arg_phase_ff;
      hz_acc_in    = hz_acc_ff;
      ms_acc_in    = ms_acc_ff;
      if (step) begin
         if (is_term) begin
            line_len_in  = '0;
            flags_in     = '1;
            arg_phase_in = ARG_WAIT_HZ;
            hz_acc_in    = '0;
            ms_acc_in    = '0;
         end else if (line_len_ff < LEN_LIMIT) begin
            for (int k = 0; k < KEYWORD_COUNT; k++) begin
               if (line_len_cmp < CMP_W'(KEYWORD_LEN[k])) begin
                  if (KEYWORD_CHARS[k][line_len_ff[KEYWORD_POS_W-1:0]] != rx_byte) begin
                     flags_in[k] = 1'b0;
                  end
               end else if (k != BEEP_BIT) begin
                  flags_in[k] = 1'b0;
               end
            end
            if (line_len_cmp >= CMP_W'(ARG_START)) begin
               case (arg_phase_ff)
                  ARG_WAIT_HZ: begin
                     if (digit) begin
                        hz_acc_in    = hz_acc_next;
                        arg_phase_in = ARG_HZ;
                     end else if (!blank) begin
                        arg_phase_in = ARG_DONE;
                     end
                  end
                  ARG_HZ: begin
                     if (digit) begin
                        hz_acc_in = hz_acc_next;
                     end else if (blank) begin
                        arg_phase_in = ARG_WAIT_MS;
                     end else begin
                        arg_phase_in = ARG_DONE;
                     end
                  end
                  ARG_WAIT_MS: begin
                     if (digit) begin
                        ms_acc_in    = ms_acc_next;
                        arg_phase_in = ARG_MS;
                     end else if (!blank) begin
                        arg_phase_in = ARG_DONE;
                     end
                  end
                  ARG_MS: begin
                     if (digit) begin
                        ms_acc_in = ms_acc_next;
                     end else begin
                        arg_phase_in = ARG_DONE;
                     end
                  end
                  default: begin
                     arg_phase_in = ARG_DONE;
                  end
               endcase
            end
            line_len_in = line_len_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_len_ff  <= '0;
         flags_ff     <= '1;
         arg_phase_ff <= ARG_WAIT_HZ;
         hz_acc_ff    <= '0;
         ms_acc_ff    <= '0;
      end else begin
         line_len_ff  <= line_len_in;
         flags_ff     <= flags_in;
         arg_phase_ff <= arg_phase_in;
         hz_acc_ff    <= hz_acc_in;
         ms_acc_ff    <= ms_acc_in;
      end
   end

endmodule

>>> dv/text_command_line_decoder_tb.sv
// ----------------------------------------------------------------------------
// Text command line decoder testbench
// Streams command lines into the decoder one byte per item: fixed commands,
// beep lines with blank, digit, sign and overflow argument patterns, near
// misses, long lines and raw noise. Both channels idle in random bursts. An
// in-bench decoder predicts every command, and each result is compared
// against the oldest predicted one. Tone defaults are rewritten between
// phases, including the extremes, zero and unused indexes.
// ----------------------------------------------------------------------------
module text_command_line_decoder_tb;
   import tcld_pkg::*;

   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_VT    = 8'h0B;
   localparam logic [7:0] BYTE_FF    = 8'h0C;
   localparam logic [7:0] BYTE_ZERO  = 8'h30;
   localparam logic [7:0] BYTE_NINE  = 8'h39;
   localparam logic [7:0] BYTE_NUL   = 8'h00;

   localparam logic [7:0] CSR_UNUSED_LOW = 8'd2;
   localparam logic [7:0] CSR_UNUSED_TOP = 8'hFF;

   localparam int LINE_KEEP  = 79;
   localparam int BEEP_SLOT  = 6;
   localparam int ARG_OFFSET = 4;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_PRINTED = 100;

   typedef struct packed {
      cmd_code_type code;
      logic [15:0]  hz;
      logic [15:0]  ms;
   } command_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_command_code;
   logic [15:0] rsp_tone_hz;
   logic [15:0] rsp_tone_ms;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = 8'h00;
   logic [15:0] csr_wdata = 16'h0000;

   text_command_line_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command_code (rsp_command_code),
      .rsp_tone_hz      (rsp_tone_hz),
      .rsp_tone_ms      (rsp_tone_ms),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   string cmd_words [7] = '{"help", "status", "led1 on", "led1 off",
                            "led2 on", "led2 off", "beep"};

   logic [7:0]    tx_bytes [$];
   command_type   pending_commands [$];
   int            queued_count = 0;
   int            accepted_count = 0;
   int            mismatches = 0;
   bit            calm = 1'b0;

   logic [15:0]   tone_hz_dflt = 16'd2000;
   logic [15:0]   tone_ms_dflt = 16'd80;
   int            kept_len = 0;
   logic [6:0]    word_flags = 7'h7F;
   arg_phase_type arg_state = ARG_WAIT_HZ;
   logic [31:0]   hz_sum = 32'h0;
   logic [31:0]   ms_sum = 32'h0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic blank_char(input logic [7:0] c);
      return c == BYTE_SPACE || c == BYTE_TAB || c == BYTE_VT || c == BYTE_FF;
   endfunction

   function automatic logic [31:0] add_decimal(input logic [31:0] acc, input logic [3:0] d);
      logic [35:0] v;
      v = 36'(acc) * 36'd10 + 36'(d);
      return (v > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic void clear_line();
      kept_len = 0;
      word_flags = 7'h7F;
      arg_state = ARG_WAIT_HZ;
      hz_sum = 32'h0;
      ms_sum = 32'h0;
   endfunction

   function automatic void scan_argument(input logic [7:0] c);
      logic       digit;
      logic [3:0] d;
      digit = c >= BYTE_ZERO && c <= BYTE_NINE;
      d = 4'(c - BYTE_ZERO);
      case (arg_state)
         ARG_WAIT_HZ: begin
            if (digit) begin
               hz_sum = add_decimal(hz_sum, d);
               arg_state = ARG_HZ;
            end else if (!blank_char(c)) begin
               arg_state = ARG_DONE;
            end
         end
         ARG_HZ: begin
            if (digit) hz_sum = add_decimal(hz_sum, d);
            else if (blank_char(c)) arg_state = ARG_WAIT_MS;
            else arg_state = ARG_DONE;
         end
         ARG_WAIT_MS: begin
            if (digit) begin
               ms_sum = add_decimal(ms_sum, d);
               arg_state = ARG_MS;
            end else if (!blank_char(c)) begin
               arg_state = ARG_DONE;
            end
         end
         ARG_MS: begin
            if (digit) ms_sum = add_decimal(ms_sum, d);
            else arg_state = ARG_DONE;
         end
         default: arg_state = ARG_DONE;
      endcase
   endfunction

   function automatic void decode_line_byte(input logic [7:0] c);
      command_type cmd;
      logic [7:0]  ch;
      bit          found;
      if (c != BYTE_CR && c != BYTE_LF) begin
         if (kept_len < LINE_KEEP) begin
            for (int k = 0; k < 7; k++) begin
               if (kept_len < cmd_words[k].len()) begin
                  ch = cmd_words[k][kept_len];
                  if (ch != c) word_flags[k] = 1'b0;
               end else if (k != BEEP_SLOT) begin
                  word_flags[k] = 1'b0;
               end
            end
            if (kept_len >= ARG_OFFSET) scan_argument(c);
            kept_len++;
         end
      end else if (kept_len != 0) begin
         cmd.code = CMD_UNKNOWN;
         cmd.hz = 16'h0;
         cmd.ms = 16'h0;
         found = 1'b0;
         for (int k = 0; k < BEEP_SLOT; k++) begin
            if (!found && word_flags[k] && kept_len == cmd_words[k].len()) begin
               cmd.code = cmd_code_type'(k);
               found = 1'b1;
            end
         end
         if (!found && word_flags[BEEP_SLOT] && kept_len >= ARG_OFFSET) begin
            cmd.code = CMD_BEEP;
            cmd.hz = (hz_sum != 0) ? hz_sum[15:0] : tone_hz_dflt;
            cmd.ms = (ms_sum != 0) ? ms_sum[15:0] : tone_ms_dflt;
         end
         pending_commands.push_back(cmd);
         clear_line();
      end else begin
         clear_line();
      end
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   // driver
   int  send_gap = 0;
   bit  next_valid;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            decode_line_byte(req_rx_byte);
            accepted_count++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (tx_bytes.size() > 0) begin
               if (!calm && $urandom_range(0, 11) == 0) begin
                  send_gap = $urandom_range(1, 18);
               end else begin
                  req_rx_byte <= tx_bytes.pop_front();
                  next_valid = 1'b1;
               end
            end
         end
         req_valid <= next_valid;
      end
   end

   // monitor
   int          stall_left = 0;
   command_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_commands.size() == 0) begin
               report_mismatch($sformatf("unexpected command code %0d hz %0d ms %0d",
                  rsp_command_code, rsp_tone_hz, rsp_tone_ms));
            end else begin
               want = pending_commands.pop_front();
               if (rsp_command_code !== want.code || rsp_tone_hz !== want.hz ||
                   rsp_tone_ms !== want.ms) begin
                  report_mismatch($sformatf(
                     "code %0d hz %0d ms %0d, expected code %0d hz %0d ms %0d",
                     rsp_command_code, rsp_tone_hz, rsp_tone_ms,
                     want.code, want.hz, want.ms));
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push_byte(input logic [7:0] b);
      tx_bytes.push_back(b);
      queued_count++;
   endtask

   task automatic push_word(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(8'(s[i]));
   endtask

   task automatic push_line(input string s, input logic [7:0] term);
      push_word(s);
      push_byte(term);
   endtask

   task automatic push_terminator();
      case ($urandom_range(0, 3))
         0: push_byte(BYTE_CR);
         1: push_byte(BYTE_LF);
         2: begin
            push_byte(BYTE_CR);
            push_byte(BYTE_LF);
         end
         default: begin
            push_byte(BYTE_LF);
            push_byte(BYTE_LF);
         end
      endcase
   endtask

   task automatic push_blanks(input int n);
      logic [7:0] pick [4];
      pick = '{BYTE_SPACE, BYTE_TAB, BYTE_VT, BYTE_FF};
      for (int i = 0; i < n; i++) push_byte(pick[$urandom_range(0, 3)]);
   endtask

   task automatic push_digits(input int n);
      for (int i = 0; i < n; i++) push_byte(BYTE_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic push_random_line();
      string w;
      int    pos;
      int    mode;
      int    n;
      w = cmd_words[$urandom_range(0, 6)];
      case ($urandom_range(0, 9))
         0, 1: push_word(w);
         2, 3, 4: begin
            push_word("beep");
            push_blanks($urandom_range(0, 3));
            if ($urandom_range(0, 5) != 0)
               push_digits($urandom_range(0, 3) == 0 ? $urandom_range(6, 12)
                                                     : $urandom_range(1, 5));
            push_blanks($urandom_range(0, 2));
            if ($urandom_range(0, 3) != 0)
               push_digits($urandom_range(0, 3) == 0 ? $urandom_range(6, 12)
                                                     : $urandom_range(1, 5));
            if ($urandom_range(0, 3) == 0) push_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) == 0) push_digits($urandom_range(1, 3));
         end
         5: begin
            pos = $urandom_range(0, w.len() - 1);
            mode = $urandom_range(0, 2);
            for (int i = 0; i < w.len(); i++) begin
               if (!(mode == 1 && i >= pos))
                  push_byte((mode == 0 && i == pos) ? 8'($urandom_range(0, 255)) : 8'(w[i]));
            end
            if (mode == 2) push_byte(8'($urandom_range(32, 126)));
         end
         6, 7: begin
            n = $urandom_range(1, 15);
            for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
         end
         8: begin
            n = $urandom_range(70, 110);
            if ($urandom_range(0, 1) == 0) push_word(w);
            for (int i = 0; i < n; i++) push_byte(8'($urandom_range(32, 126)));
         end
         default: ;
      endcase
      push_terminator();
   endtask

   task automatic write_csr(input logic [7:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_TONE_HZ) tone_hz_dflt = data;
      else if (idx == CSR_TONE_MS) tone_ms_dflt = data;
   endtask

   task automatic drain();
      while (accepted_count != queued_count || pending_commands.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int n_bytes);
      int goal;
      push_line("beep", BYTE_LF);
      push_line("beep 0 0", BYTE_CR);
      push_line("beep 321", BYTE_LF);
      goal = queued_count + n_bytes;
      while (queued_count < goal) push_random_line();
      drain();
   endtask

   initial begin
      string s;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      push_byte(BYTE_CR);
      push_byte(BYTE_LF);
      push_line("help", BYTE_CR);
      push_line("status", BYTE_LF);
      push_line("led1 on", BYTE_CR);
      push_byte(BYTE_LF);
      push_line("led1 off", BYTE_LF);
      push_line("led2 on", BYTE_CR);
      push_line("led2 off", BYTE_LF);
      push_line("beep", BYTE_LF);
      push_line("beep 440 250", BYTE_CR);
      push_line("beep\t\v\f 0 0", BYTE_LF);
      push_line("beep 99999999999 70000", BYTE_LF);
      push_line("beep12  34 56", BYTE_CR);
      push_line("beep +5 7", BYTE_LF);
      push_line("beepx 12", BYTE_CR);
      push_line("beep 123", BYTE_LF);
      push_line("help ", BYTE_LF);
      push_line("led1 o", BYTE_CR);
      push_line("HELP", BYTE_LF);
      push_byte(BYTE_NUL);
      push_byte(BYTE_LF);
      push_byte(8'hFF);
      push_byte(8'h80);
      push_byte(BYTE_CR);
      s = {"beep", {70{" "}}, "1234567890"};
      push_line(s, BYTE_LF);
      s = {"status", {100{"z"}}};
      push_line(s, BYTE_CR);
      drain();

      write_csr(CSR_TONE_HZ, 16'd1);
      write_csr(CSR_TONE_MS, 16'hFFFF);
      run_phase(300);

      write_csr(CSR_TONE_HZ, 16'hFFFF);
      write_csr(CSR_TONE_MS, 16'd1);
      run_phase(300);

      write_csr(CSR_TONE_HZ, 16'd0);
      write_csr(CSR_TONE_MS, 16'd0);
      run_phase(200);

      write_csr(CSR_TONE_HZ, 16'd1000);
      write_csr(CSR_TONE_MS, 16'd500);
      write_csr(CSR_UNUSED_LOW, 16'h1234);
      write_csr(CSR_UNUSED_TOP, 16'h4321);
      run_phase(300);

      write_csr(CSR_TONE_HZ, 16'($urandom_range(1, 65535)));
      write_csr(CSR_TONE_MS, 16'($urandom_range(1, 65535)));
      run_phase(200);

      calm = 1'b1;
      write_csr(CSR_TONE_HZ, 16'($urandom_range(1, 65535)));
      write_csr(CSR_TONE_MS, 16'($urandom_range(1, 65535)));
      run_phase(200);

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/tcld_pkg.sv
sv/tcld_digit_acc.sv
sv/tcld_line_state.sv
sv/text_command_line_decoder.sv
dv/text_command_line_decoder_tb.sv
